>>> sv/kpi_pkg.sv
// Package for the keyframe position interpolator.
// Holds widths, codes, the controller state type and the divider status type.
// No dependencies.
`default_nettype none

package kpi_pkg;

   localparam int TIME_W          = 16;
   localparam int FRAC_W          = 16;
   localparam int CNT_W           = 7;
   localparam int INDEX_W         = 6;
   localparam int STATUS_W        = 2;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int DEF_MAX_KEYS    = 64;
   localparam int DEF_POS_WIDTH   = 24;

   localparam logic [CNT_W-1:0] KEY_COUNT_RESET = 7'd1;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLAMP = 2'd2;

   localparam logic REG_KEY_COUNT = 1'b0;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RD_START,
      ST_RD_END,
      ST_SETUP,
      ST_DIVIDE,
      ST_LERP,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> sv/keyframe_position_interpolator_unit.sv
// Top level of the keyframe position interpolator: control sequencer and register port.
// Uses kpi_pkg, kpi_key_mem, kpi_div and kpi_lerp.
`default_nettype none

// A load word writes one key into the table if its index is below the key capacity
// and returns an acknowledge from the done state once the output register is free.
// A query word searches the table one key per cycle through the single read port
// of the key memory, then reads the two keys of its segment, runs a sixteen-step
// divider for the factor when the query lies within the segment and blends the
// three coordinates through one shared multiplier. A query that clamps, or one on a
// table of one key, skips the divider and blender. One word is in work at a time;
// the next is taken as soon as the result sits in the output register, even while
// that result is still stalled.

module keyframe_position_interpolator_unit
   import kpi_pkg::*;
#(
   parameter int MAX_KEYS  = DEF_MAX_KEYS,
   parameter int POS_WIDTH = DEF_POS_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic                         req_action,
   input  wire logic [INDEX_W-1:0]           req_key_index,
   input  wire logic [TIME_W-1:0]            req_key_time,
   input  wire logic signed [POS_WIDTH-1:0]  req_key_x,
   input  wire logic signed [POS_WIDTH-1:0]  req_key_y,
   input  wire logic signed [POS_WIDTH-1:0]  req_key_z,
   input  wire logic [TIME_W-1:0]            req_query_time,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic signed [POS_WIDTH-1:0]  rsp_pos_x,
   output      logic signed [POS_WIDTH-1:0]  rsp_pos_y,
   output      logic signed [POS_WIDTH-1:0]  rsp_pos_z,
   output      logic [INDEX_W-1:0]           rsp_segment,
   output      logic [STATUS_W-1:0]          rsp_status,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]        csr_pwdata,
   output      logic [CSR_DATA_W-1:0]        csr_prdata,
   output      logic                         csr_pready
);

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int KEY_W = TIME_W + 3 * POS_WIDTH;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam logic [CNT_W-1:0] KEY_CAP =
      CNT_W'((MAX_KEYS > CNT_MAX) ? CNT_MAX : MAX_KEYS);

   ctrl_state_type state_ff, state_in;

   logic [CNT_W-1:0]            key_count_ff;
   logic [TIME_W-1:0]           qt_ff;
   logic [CNT_W-1:0]            n_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic [CNT_W-1:0]            seg_ff;
   logic [STATUS_W-1:0]         status_ff;
   logic                        direct_ff;
   logic [TIME_W-1:0]           t0_ff;
   logic signed [POS_WIDTH-1:0] start_x_ff, start_y_ff, start_z_ff;
   logic signed [POS_WIDTH-1:0] end_x_ff, end_y_ff, end_z_ff;
   logic [FRAC_W-1:0]           factor_ff;
   logic [1:0]                  issue_cnt_ff;
   logic [1:0]                  got_cnt_ff;
   logic signed [POS_WIDTH-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic                        rsp_valid_ff;
   logic signed [POS_WIDTH-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic [INDEX_W-1:0]          rsp_segment_ff;
   logic [STATUS_W-1:0]         rsp_status_ff;

   logic                        req_fire;
   logic                        out_free;
   logic                        csr_write;
   logic [CNT_W-1:0]            n_next;
   logic [CNT_W-1:0]            last_idx;
   logic                        mem_wr_en;
   logic [AW-1:0]               mem_raddr;
   logic [KEY_W-1:0]            mem_wdata;
   logic [KEY_W-1:0]            mem_rdata;
   logic [TIME_W-1:0]           rd_time;
   logic signed [POS_WIDTH-1:0] rd_x, rd_y, rd_z;
   logic                        hit;
   logic                        in_range;
   logic                        div_start;
   div_status_type              div_stat;
   logic [FRAC_W-1:0]           div_quotient;
   logic                        lerp_go;
   logic signed [POS_WIDTH-1:0] lerp_a, lerp_b;
   logic                        lerp_valid;
   logic signed [POS_WIDTH-1:0] lerp_result;

   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      if (key_count_ff == '0) begin
         n_next = CNT_W'(1);
      end else if (key_count_ff > KEY_CAP) begin
         n_next = KEY_CAP;
      end else begin
         n_next = key_count_ff;
      end
   end

   assign last_idx = n_ff - CNT_W'(1);

   assign rd_time = mem_rdata[KEY_W-1 -: TIME_W];
   assign rd_x    = mem_rdata[3*POS_WIDTH-1 -: POS_WIDTH];
   assign rd_y    = mem_rdata[2*POS_WIDTH-1 -: POS_WIDTH];
   assign rd_z    = mem_rdata[POS_WIDTH-1:0];

   assign hit      = qt_ff < rd_time;
   assign in_range = (qt_ff >= t0_ff) && (rd_time > t0_ff);

   assign mem_wr_en = req_fire && (req_action == ACTION_LOAD) &&
                      ({1'b0, req_key_index} < KEY_CAP);
   assign mem_wdata = {req_key_time, req_key_x, req_key_y, req_key_z};

   assign div_start = (state_ff == ST_SETUP) && in_range;
   assign lerp_go   = (state_ff == ST_LERP) && (issue_cnt_ff <= AXIS_Z);

   always_comb begin
      case (issue_cnt_ff)
         AXIS_X: begin
            lerp_a = start_x_ff;
            lerp_b = end_x_ff;
         end
         AXIS_Y: begin
            lerp_a = start_y_ff;
            lerp_b = end_y_ff;
         end
         default: begin
            lerp_a = start_z_ff;
            lerp_b = end_z_ff;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mem_raddr = AW'(seg_ff);
      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = AW'(1);
            if (req_fire) begin
               if (req_action == ACTION_LOAD) begin
                  state_in = ST_DONE;
               end else if (n_next == CNT_W'(1)) begin
                  state_in = ST_RD_START;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            mem_raddr = AW'(idx_ff + CNT_W'(1));
            if (hit || (idx_ff == last_idx)) begin
               state_in = ST_RD_START;
            end
         end
         ST_RD_START: begin
            mem_raddr = AW'(seg_ff);
            state_in  = ST_RD_END;
         end
         ST_RD_END: begin
            mem_raddr = AW'(seg_ff + CNT_W'(1));
            state_in  = direct_ff ? ST_DONE : ST_SETUP;
         end
         ST_SETUP: begin
            state_in = in_range ? ST_DIVIDE : ST_LERP;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            if (lerp_valid && (got_cnt_ff == AXIS_Z)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= KEY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         issue_cnt_ff <= '0;
         got_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write && (csr_paddr[CSR_ADDR_W-1] == REG_KEY_COUNT)) begin
            key_count_ff <= csr_pwdata[CNT_W-1:0];
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_LERP) begin
            if (lerp_go) begin
               issue_cnt_ff <= issue_cnt_ff + 2'd1;
            end
            if (lerp_valid) begin
               got_cnt_ff <= got_cnt_ff + 2'd1;
            end
         end else begin
            issue_cnt_ff <= '0;
            got_cnt_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               qt_ff     <= req_query_time;
               n_ff      <= n_next;
               idx_ff    <= CNT_W'(1);
               direct_ff <= (n_next == CNT_W'(1));
               pos_x_ff  <= '0;
               pos_y_ff  <= '0;
               pos_z_ff  <= '0;
               if (req_action == ACTION_LOAD) begin
                  seg_ff    <= CNT_W'(req_key_index);
                  status_ff <= STATUS_LOAD;
               end else begin
                  seg_ff    <= '0;
                  status_ff <= STATUS_OK;
               end
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               seg_ff <= idx_ff - CNT_W'(1);
            end else if (idx_ff == last_idx) begin
               seg_ff    <= idx_ff;
               status_ff <= STATUS_CLAMP;
               direct_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         ST_RD_END: begin
            t0_ff      <= rd_time;
            start_x_ff <= rd_x;
            start_y_ff <= rd_y;
            start_z_ff <= rd_z;
            pos_x_ff   <= rd_x;
            pos_y_ff   <= rd_y;
            pos_z_ff   <= rd_z;
         end
         ST_SETUP: begin
            end_x_ff  <= rd_x;
            end_y_ff  <= rd_y;
            end_z_ff  <= rd_z;
            factor_ff <= '0;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               factor_ff <= div_quotient;
            end
         end
         ST_LERP: begin
            if (lerp_valid) begin
               pos_z_ff <= lerp_result;
               pos_y_ff <= pos_z_ff;
               pos_x_ff <= pos_y_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_pos_x_ff   <= pos_x_ff;
               rsp_pos_y_ff   <= pos_y_ff;
               rsp_pos_z_ff   <= pos_z_ff;
               rsp_segment_ff <= seg_ff[INDEX_W-1:0];
               rsp_status_ff  <= status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   kpi_key_mem #(
      .DEPTH  (MAX_KEYS),
      .DATA_W (KEY_W)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(req_key_index)),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   kpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (qt_ff - t0_ff),
      .den      (rd_time - t0_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   kpi_lerp #(
      .POS_W (POS_WIDTH)
   ) u_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lerp_go),
      .a         (lerp_a),
      .b         (lerp_b),
      .factor    (factor_ff),
      .out_valid (lerp_valid),
      .result    (lerp_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_pos_z   = rsp_pos_z_ff;
   assign rsp_segment = rsp_segment_ff;
   assign rsp_status  = rsp_status_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[CSR_ADDR_W-1] == REG_KEY_COUNT) ?
                        CSR_DATA_W'(key_count_ff) : '0;

`ifndef NO_ASSERTIONS
   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_stat.busy || div_stat.done))
      else $error("divider idle while the sequencer waits on it");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((idx_ff != '0) && (idx_ff < n_ff)))
      else $error("search index outside the key range");

   a_lerp_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LERP) |-> (got_cnt_ff <= issue_cnt_ff))
      else $error("blend result without a matching issue");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result word raised outside the done state");
`endif

endmodule

`default_nettype wire

>>> sv/kpi_key_mem.sv
// Key table memory: one write port and one registered read port.
// Each entry packs a key time and its three position coordinates.
// No dependencies.
`default_nettype none

module kpi_key_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 88
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic [DATA_W-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
   output      logic [DATA_W-1:0]                 rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/kpi_div.sv
// Restoring divider that forms the 16-bit interpolation factor, one bit a cycle.
// The numerator must be below the denominator. Uses kpi_pkg.
`default_nettype none

module kpi_div
   import kpi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [TIME_W-1:0]   num,
   input  wire logic [TIME_W-1:0]   den,
   output      div_status_type      stat,
   output      logic [FRAC_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(FRAC_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

   logic [TIME_W-1:0] rem_ff;
   logic [TIME_W-1:0] den_ff;
   logic [FRAC_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [TIME_W:0]   shifted;
   logic              fits;

   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         den_ff <= den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? TIME_W'(shifted - {1'b0, den_ff}) : shifted[TIME_W-1:0];
         quo_ff <= {quo_ff[FRAC_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

>>> sv/kpi_lerp.sv
// Two-stage blend unit: start + factor * (end - start), rounded and saturated.
// One coordinate enters per cycle. Uses kpi_pkg.
`default_nettype none

module kpi_lerp
   import kpi_pkg::*;
#(
   parameter int POS_W = DEF_POS_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [POS_W-1:0]  a,
   input  wire logic signed [POS_W-1:0]  b,
   input  wire logic [FRAC_W-1:0]        factor,
   output      logic                     out_valid,
   output      logic signed [POS_W-1:0]  result
);

   localparam int DW = POS_W + 1;
   localparam int PW = DW + FRAC_W + 1;
   localparam int SW = POS_W + FRAC_W + 3;
   localparam int RW = SW - FRAC_W;
   localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC_W - 1));
   localparam logic signed [RW-1:0] HI   = RW'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] LO   = RW'(-(64'sd1 <<< (POS_W - 1)));

   logic signed [DW-1:0]     diff;
   logic signed [FRAC_W:0]   fac_s;
   logic signed [PW-1:0]     prod_ff;
   logic signed [POS_W-1:0]  a_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [SW-1:0]     a_ext;
   logic signed [SW-1:0]     prod_ext;
   logic signed [SW-1:0]     sum;
   logic signed [RW-1:0]     rnd;
   logic signed [POS_W-1:0]  sat;
   logic signed [POS_W-1:0]  result_ff;

   assign diff     = {b[POS_W-1], b} - {a[POS_W-1], a};
   assign fac_s    = {1'b0, factor};
   assign a_ext    = {{(SW-POS_W){a_ff[POS_W-1]}}, a_ff} <<< FRAC_W;
   assign prod_ext = {{(SW-PW){prod_ff[PW-1]}}, prod_ff};
   assign sum      = a_ext + prod_ext + HALF;
   assign rnd      = sum[SW-1:FRAC_W];

   always_comb begin
      if (rnd > HI) begin
         sat = HI[POS_W-1:0];
      end else if (rnd < LO) begin
         sat = LO[POS_W-1:0];
      end else begin
         sat = rnd[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= diff * fac_s;
      a_ff      <= a;
      result_ff <= sat;
   end

   assign out_valid = v2_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire
